>>> rtl/hex_grid_line_draw_macros.svh
// Assertion macros shared by the hex grid line draw RTL.
`ifndef HEX_GRID_LINE_DRAW_MACROS_SVH
`define HEX_GRID_LINE_DRAW_MACROS_SVH

// Check on every rising edge outside reset.
`define HGL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check on every rising edge, reset included.
`define HGL_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/hgl_pkg.sv
// Constants, widths and controller/datapath types for the hex grid line draw.
`default_nettype none

package hgl_pkg;

  localparam int GRID_RADIUS = 31;
  localparam int FRAC_BITS   = 20;

  localparam int COORD_W = 6;              // q and r on the channels
  localparam int S_W     = 7;              // s on the result channel
  localparam int IDX_W   = 6;              // line length and point index
  localparam int CI_W    = 9;              // integer working width for cells
  localparam int FX_W    = FRAC_BITS + 9;  // fixed-point point coordinate
  localparam int PS_W    = FX_W + 1;       // fixed-point s, minus q minus r
  localparam int RC_W    = FRAC_BITS + 1;  // reciprocal entry, up to one
  localparam int RC_DEPTH = 2 ** IDX_W;

  localparam int unsigned FX_ONE  = 32'd1 << FRAC_BITS;
  localparam int unsigned FX_HALF = 32'd1 << (FRAC_BITS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;     // request channel may be taken
    logic sat;       // saturate both ends
    logic hex_dist;  // form deltas and hex distance
    logic setup;     // load step sizes and origin
    logic issue;     // launch the next point down the pipeline
  } hgl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_valid;   // a request is offered
    logic advance;     // point pipeline moves this cycle
    logic last_point;  // the next point issued is the final one
  } hgl_sts_t;

endpackage

`default_nettype wire

>>> rtl/hgl_channels.sv
// Request and cell channel interfaces of the hex grid line draw.
`default_nettype none

interface hgl_req_if import hgl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_q;
  logic signed [COORD_W-1:0] start_r;
  logic signed [COORD_W-1:0] end_q;
  logic signed [COORD_W-1:0] end_r;

  modport source (output valid, start_q, start_r, end_q, end_r, input ready);
  modport sink   (input valid, start_q, start_r, end_q, end_r, output ready);
endinterface

interface hgl_cell_if import hgl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] cell_q;
  logic signed [COORD_W-1:0] cell_r;
  logic signed [S_W-1:0]     cell_s;
  logic                      last_cell;

  modport source (output valid, cell_q, cell_r, cell_s, last_cell, input ready);
  modport sink   (input valid, cell_q, cell_r, cell_s, last_cell, output ready);
endinterface

`default_nettype wire

>>> rtl/hex_grid_line_draw.sv
// Top level of the hex grid line draw: controller and datapath.
// Usage:
//   req   : one request carries a start and an end cell (q, r, two's
//           complement). Ends outside the hexagon of the grid radius are
//           pulled onto its edge first.
//   cells : for each request the N+1 cells of the straight line, start
//           first, where N is the hex distance; last_cell marks the final one.
//           cell_s always equals minus cell_q minus cell_r.
// Both channels move a request or a cell on a rising edge with valid
// and ready high.
// Sequence: the request is taken in the idle state, three setup steps
// follow (saturate, distance, reciprocal and step multiply), then the
// sequencer launches one point a cycle, while the receiver keeps up, into
// a three-stage pipeline (accumulate, round, select). A new request is
// taken once the last point is launched while the tail drains.
// Reset (rst, synchronous, active high) empties the pipeline and puts the
// sequencer in idle. When the receiver holds cells.ready low while a cell
// is offered, the whole point pipeline and the point issue of the
// sequencer stall and the offered cell holds.
`default_nettype none

module hex_grid_line_draw import hgl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hgl_req_if.sink     req,
  hgl_cell_if.source  cells
);

  hgl_cmd_t cmd;
  hgl_sts_t sts;

  // Sequencer: setup steps and point issue.
  hgl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Arithmetic and result pipeline; owns both channels.
  hgl_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .sts   (sts),
    .req   (req),
    .cells (cells)
  );

endmodule

`default_nettype wire

>>> rtl/hgl_ctrl.sv
// Sequencing state machine of the hex grid line draw.
`default_nettype none

module hgl_ctrl import hgl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  hgl_sts_t  sts,
  output hgl_cmd_t  cmd
);

  `include "hex_grid_line_draw_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SAT   = 3'd1;
  localparam logic [2:0] ST_DIST  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       start;

  assign start = (state == ST_IDLE) && sts.req_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SAT;
      end
      ST_SAT:   state_next = ST_DIST;
      ST_DIST:  state_next = ST_SETUP;
      ST_SETUP: state_next = ST_RUN;
      ST_RUN: begin
        // drop back to idle once the final point has been launched
        if (sts.advance && sts.last_point) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.ready    = (state == ST_IDLE);
    cmd.sat      = (state == ST_SAT);
    cmd.hex_dist = (state == ST_DIST);
    cmd.setup    = (state == ST_SETUP);
    cmd.issue    = (state == ST_RUN) && sts.advance;
  end

  `HGL_ASSERT(a_accept_to_sat, (start) |=> (state == ST_SAT),
              "request taken but no saturate step")
  `HGL_ASSERT(a_last_to_idle, (cmd.issue && sts.last_point) |=> (state == ST_IDLE),
              "final point issued but sequencer still busy")

endmodule

`default_nettype wire

>>> rtl/hgl_datapath.sv
// Setup arithmetic, point accumulators and cube-rounding pipeline.
`default_nettype none

module hgl_datapath import hgl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  hgl_cmd_t        cmd,
  output hgl_sts_t        sts,
  hgl_req_if.sink         req,
  hgl_cell_if.source      cells
);

  `include "hex_grid_line_draw_macros.svh"

  typedef struct packed {
    logic signed [COORD_W-1:0] q;
    logic signed [COORD_W-1:0] r;
  } cell_t;

  typedef struct packed {
    logic signed [CI_W-1:0] c;
    logic [FRAC_BITS:0]     e;
  } rnd_t;

  localparam logic signed [CI_W-1:0] RAD = CI_W'(GRID_RADIUS);

  function automatic logic signed [CI_W-1:0] clamp_rad(input logic signed [CI_W-1:0] x);
    logic signed [CI_W-1:0] y;
    y = x;
    if (x > RAD) y = RAD;
    else if (x < -RAD) y = -RAD;
    return y;
  endfunction

  // Pull an end into the hexagon of the grid radius.
  function automatic cell_t sat_cell(input logic signed [COORD_W-1:0] q,
                                     input logic signed [COORD_W-1:0] r);
    logic signed [CI_W-1:0] qc;
    logic signed [CI_W-1:0] rc;
    logic signed [CI_W-1:0] sum;
    cell_t                  res;
    qc  = clamp_rad(CI_W'(q));
    rc  = clamp_rad(CI_W'(r));
    sum = qc + rc;
    if (sum > RAD) rc = RAD - qc;
    else if (sum < -RAD) rc = -RAD - qc;
    res.q = COORD_W'(qc);
    res.r = COORD_W'(rc);
    return res;
  endfunction

  // Round to nearest, halves away from zero, and give the rounding error.
  function automatic rnd_t round_fx(input logic signed [PS_W-1:0] x);
    logic [PS_W-1:0]        mag;
    logic [PS_W-1:0]        up;
    logic [PS_W-1:0]        base;
    logic signed [PS_W-1:0] diff;
    logic [PS_W-1:0]        ci;
    rnd_t                   res;
    mag  = x[PS_W-1] ? PS_W'(-x) : PS_W'(x);
    up   = mag + PS_W'(FX_HALF);
    ci   = up >> FRAC_BITS;
    base = {up[PS_W-1:FRAC_BITS], FRAC_BITS'(0)};
    diff = $signed(mag - base);
    res.e = (FRAC_BITS + 1)'(diff[PS_W-1] ? -diff : diff);
    res.c = x[PS_W-1] ? -$signed(CI_W'(ci)) : $signed(CI_W'(ci));
    return res;
  endfunction

  // Reciprocal table, round(2^FRAC_BITS / n), length zero read as one.
  logic [RC_W-1:0] rc_tbl [0:RC_DEPTH-1];

  for (genvar g = 0; g < RC_DEPTH; g++) begin : g_rc
    localparam int unsigned D   = (g == 0) ? 1 : g;
    localparam int unsigned RCV = (FX_ONE + D / 2) / D;
    assign rc_tbl[g] = RC_W'(RCV);
  end

  // Request capture and setup registers.
  logic signed [COORD_W-1:0] in_sq, in_sr, in_eq, in_er;
  cell_t                     a_cell, b_cell;
  logic signed [CI_W-1:0]    dq, dr;
  logic [IDX_W-1:0]          n;
  logic signed [FX_W-1:0]    step_q, step_r;
  logic signed [FX_W-1:0]    acc_q, acc_r;
  logic [IDX_W-1:0]          idx;

  // Point pipeline.
  logic                      s1_valid, s2_valid, o_valid;
  logic signed [FX_W-1:0]    s1_q, s1_r;
  logic                      s1_last, s2_last, o_last;
  rnd_t                      s2_q, s2_r, s2_s;
  logic signed [COORD_W-1:0] o_q, o_r;
  logic signed [S_W-1:0]     o_s;
  logic                      adv;

  logic signed [CI_W-1:0]    dq_c, dr_c, ds_c;
  logic [CI_W-1:0]           dist_sum;
  logic signed [FX_W-1:0]    rc_s;
  logic signed [PS_W-1:0]    ps;
  logic signed [CI_W-1:0]    cq_sel, cr_sel;
  logic signed [CI_W-1:0]    cq_cl, cr_cl;

  assign req.ready     = cmd.ready;
  assign sts.req_valid = req.valid;
  assign adv           = !o_valid || cells.ready;
  assign sts.advance   = adv;
  assign sts.last_point = (idx == n);

  always_comb begin
    dq_c     = CI_W'(b_cell.q) - CI_W'(a_cell.q);
    dr_c     = CI_W'(b_cell.r) - CI_W'(a_cell.r);
    ds_c     = -dq_c - dr_c;
    dist_sum = CI_W'(dq_c[CI_W-1] ? -dq_c : dq_c)
             + CI_W'(dr_c[CI_W-1] ? -dr_c : dr_c)
             + CI_W'(ds_c[CI_W-1] ? -ds_c : ds_c);
    rc_s     = FX_W'(rc_tbl[n]);
  end

  always_ff @(posedge clk) begin
    if (req.valid && cmd.ready) begin
      in_sq <= req.start_q;
      in_sr <= req.start_r;
      in_eq <= req.end_q;
      in_er <= req.end_r;
    end
    if (cmd.sat) begin
      a_cell <= sat_cell(in_sq, in_sr);
      b_cell <= sat_cell(in_eq, in_er);
    end
    if (cmd.hex_dist) begin
      dq <= dq_c;
      dr <= dr_c;
      n  <= IDX_W'(dist_sum >> 1);
    end
    if (cmd.setup) begin
      step_q <= FX_W'(rc_s * FX_W'(dq));
      step_r <= FX_W'(rc_s * FX_W'(dr));
      acc_q  <= (FX_W'(a_cell.q) <<< FRAC_BITS) + FX_W'(1);
      acc_r  <= (FX_W'(a_cell.r) <<< FRAC_BITS) + FX_W'(1);
      idx    <= '0;
    end else if (cmd.issue) begin
      acc_q <= acc_q + step_q;
      acc_r <= acc_r + step_r;
      idx   <= idx + IDX_W'(1);
    end
  end

  // Stage two: s from q and r, then round all three.
  assign ps = PS_W'(0) - PS_W'(s1_q) - PS_W'(s1_r);

  // Stage three: rebuild the component with the largest error, clamp.
  always_comb begin
    cq_sel = s2_q.c;
    cr_sel = s2_r.c;
    if (s2_q.e > s2_r.e && s2_q.e > s2_s.e) cq_sel = -s2_r.c - s2_s.c;
    else if (s2_r.e > s2_s.e) cr_sel = -s2_q.c - s2_s.c;
    cq_cl = clamp_rad(cq_sel);
    cr_cl = clamp_rad(cr_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      o_valid  <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q    <= acc_q;
      s1_r    <= acc_r;
      s1_last <= (idx == n);
      s2_q    <= round_fx(PS_W'(s1_q));
      s2_r    <= round_fx(PS_W'(s1_r));
      s2_s    <= round_fx(ps);
      s2_last <= s1_last;
      o_q     <= COORD_W'(cq_cl);
      o_r     <= COORD_W'(cr_cl);
      o_s     <= S_W'(-cq_cl - cr_cl);
      o_last  <= s2_last;
    end
  end

  assign cells.valid     = o_valid;
  assign cells.cell_q    = o_q;
  assign cells.cell_r    = o_r;
  assign cells.cell_s    = o_s;
  assign cells.last_cell = o_last;

  `HGL_ASSERT(a_cube_sum,
              cells.valid |-> (S_W'(cells.cell_s) + S_W'(cells.cell_q)
                               + S_W'(cells.cell_r) == S_W'(0)),
              "cell breaks q + r + s = 0")
  `HGL_ASSERT(a_in_grid,
              cells.valid |-> (cells.cell_q <= COORD_W'(GRID_RADIUS)
                               && cells.cell_q >= -COORD_W'(GRID_RADIUS)),
              "cell q outside grid radius")
  `HGL_ASSERT_RST(a_reset_empty, rst |=> !cells.valid, "cell offered straight after reset")

endmodule

`default_nettype wire

>>> bench/hex_grid_line_draw_test.sv
// Testbench for the hex grid line draw: checks every emitted cell against a line predictor.
`timescale 1ns / 1ps

module hex_grid_line_draw_test;
  import hgl_pkg::*;

  // Fixed-point unit and half unit at the block's fractional width.
  localparam longint FX_UNIT = longint'(1) << FRAC_BITS;
  localparam longint FX_MID  = longint'(1) << (FRAC_BITS - 1);

  // One expected cell of a line.
  typedef struct {
    logic signed [COORD_W-1:0] q;
    logic signed [COORD_W-1:0] r;
    logic signed [S_W-1:0]     s;
    logic                      last;
  } line_cell_t;

  logic clk = 1'b0;
  logic rst;

  hgl_req_if  line_req ();
  hgl_cell_if line_cell ();

  // Ports in declaration order: clk, rst, request channel, cell channel.
  hex_grid_line_draw i_dut (clk, rst, line_req, line_cell);

  // Cells predicted for accepted requests, oldest first.
  line_cell_t cells_due[$];

  int  lines_drawn;
  int  cells_checked;
  int  mismatches;
  bit  idle_on;          // random gaps on both channels
  int  cell_hold_cycles; // long receiver hold-off, counted down by the receiver

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------------

  function automatic longint mag(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint clamp_radius(input longint x);
    if (x < -GRID_RADIUS) return -GRID_RADIUS;
    if (x > GRID_RADIUS) return GRID_RADIUS;
    return x;
  endfunction

  // Pull a cell onto the hexagon of the grid radius: clamp q and r, then move r
  // so that q + r stays within the radius.
  function automatic void pull_into_grid(inout longint q, inout longint r);
    q = clamp_radius(q);
    r = clamp_radius(r);
    if (q + r > GRID_RADIUS)
      r = GRID_RADIUS - q;
    else if (q + r < -GRID_RADIUS)
      r = -GRID_RADIUS - q;
  endfunction

  // Nearest integer of a fixed-point value, halves away from zero.
  function automatic longint round_half_away(input longint x);
    if (x >= 0) return (x + FX_MID) >>> FRAC_BITS;
    return -((-x + FX_MID) >>> FRAC_BITS);
  endfunction

  // Work out every cell of the line for one request and queue them.
  function automatic void plot_line_cells(input logic signed [COORD_W-1:0] sq, sr, eq, er);
    longint     aq, ar, bq, br, dq, dr, ds;
    longint     span, div, step, frac_t;
    longint     base_q, base_r, pq, pr, ps;
    longint     cq, cr, cs, errq, errr, errs;
    line_cell_t c;
    aq = sq;
    ar = sr;
    bq = eq;
    br = er;
    pull_into_grid(aq, ar);
    pull_into_grid(bq, br);
    dq = bq - aq;
    dr = br - ar;
    ds = -dq - dr;
    span = (mag(dq) + mag(dr) + mag(ds)) / 2;
    div  = (span == 0) ? 1 : span;
    step = (FX_UNIT + div / 2) / div;
    // Nudge the origin by +1, +1 LSB on q and r (s picks up -2) to break ties.
    base_q = aq * FX_UNIT + 1;
    base_r = ar * FX_UNIT + 1;
    for (longint i = 0; i <= span; i++) begin
      frac_t = step * i;
      pq = base_q + ((dq * FX_UNIT * frac_t + FX_MID) >>> FRAC_BITS);
      pr = base_r + ((dr * FX_UNIT * frac_t + FX_MID) >>> FRAC_BITS);
      ps = -pq - pr;
      cq = round_half_away(pq);
      cr = round_half_away(pr);
      cs = round_half_away(ps);
      errq = mag(pq - cq * FX_UNIT);
      errr = mag(pr - cr * FX_UNIT);
      errs = mag(ps - cs * FX_UNIT);
      // Rebuild the component that strayed furthest from its integer.
      if (errq > errr && errq > errs)
        cq = -cr - cs;
      else if (errr > errs)
        cr = -cq - cs;
      cq = clamp_radius(cq);
      cr = clamp_radius(cr);
      cs = -cq - cr;
      c.q    = cq[COORD_W-1:0];
      c.r    = cr[COORD_W-1:0];
      c.s    = cs[S_W-1:0];
      c.last = (i == span);
      cells_due = {cells_due, c};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: predict on each accepted request, compare each accepted cell.
  // Both channels are sampled at the rising edge, before that edge's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cell_checker
    line_cell_t want;
    if (!rst) begin
      if (line_req.valid && line_req.ready) begin
        plot_line_cells(line_req.start_q, line_req.start_r, line_req.end_q, line_req.end_r);
        lines_drawn++;
      end
      if (line_cell.valid && line_cell.ready) begin
        cells_checked++;
        if (cells_due.size() == 0) begin
          $error("cell (%0d,%0d,%0d) arrived with none expected",
                 line_cell.cell_q, line_cell.cell_r, line_cell.cell_s);
          mismatches++;
        end else begin
          want = cells_due.pop_front();
          if (line_cell.cell_q !== want.q) begin
            $error("cell_q: expected %0d, got %0d", want.q, line_cell.cell_q);
            mismatches++;
          end
          if (line_cell.cell_r !== want.r) begin
            $error("cell_r: expected %0d, got %0d", want.r, line_cell.cell_r);
            mismatches++;
          end
          if (line_cell.cell_s !== want.s) begin
            $error("cell_s: expected %0d, got %0d", want.s, line_cell.cell_s);
            mismatches++;
          end
          if (line_cell.last_cell !== want.last) begin
            $error("last_cell: expected %0b, got %0b", want.last, line_cell.last_cell);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready low during a requested hold-off, else in random short bursts
  // while idling is on, else high.
  // ---------------------------------------------------------------------------
  initial begin : cell_receiver
    int stall_left;
    stall_left = 0;
    line_cell.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cell_hold_cycles > 0) begin
        line_cell.ready <= 1'b0;
        cell_hold_cycles--;
      end else if (stall_left > 0) begin
        line_cell.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        line_cell.ready <= 1'b0;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        line_cell.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until taken. Valid stays high into the next
  // request unless a gap is inserted first.
  task automatic send_line(input int sq, sr, eq, er);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      line_req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    line_req.valid   <= 1'b1;
    line_req.start_q <= COORD_W'(sq);
    line_req.start_r <= COORD_W'(sr);
    line_req.end_q   <= COORD_W'(eq);
    line_req.end_r   <= COORD_W'(er);
    do @(posedge clk); while (!line_req.ready);
  endtask

  // Drop valid and hold off until every predicted cell has come back.
  task automatic wait_drained();
    line_req.valid <= 1'b0;
    @(posedge clk);
    while (cells_due.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_coord(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_code(input int x);
    return (x < -32) ? -32 : ((x > 31) ? 31 : x);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme codes, full-length lines across the grid, ends outside the hexagon.
  task automatic test_grid_extremes();
    send_line(0, 0, 0, 0);          // same cell: single cell, flagged last
    send_line(-31, 0, 31, 0);       // full length along q
    send_line(31, -31, -31, 31);    // corner to corner
    send_line(0, 31, 0, -31);
    send_line(-32, -32, 31, 31);    // both ends saturated, code -32 included
    send_line(31, 31, -32, 31);
    send_line(-32, 0, 0, -32);
    send_line(31, 0, -31, 31);
    send_line(-31, 31, -31, 31);    // same corner cell
    send_line(5, -3, 5, -3);
    send_line(1, 0, 0, 0);          // one step
    send_line(-20, 7, 13, -25);
    send_line(12, 12, -12, -12);
    send_line(0, 0, 31, -31);
  endtask

  // Lines whose midpoint sits exactly on a cell edge, in all six directions:
  // the nudge must break each tie the same way.
  task automatic test_edge_ties();
    send_line(0, 0, 1, 1);
    send_line(0, 0, -1, -1);
    send_line(0, 0, 2, -1);
    send_line(0, 0, -2, 1);
    send_line(0, 0, 1, -2);
    send_line(0, 0, -1, 2);
    send_line(10, -4, 12, -5);
    send_line(-7, 3, -8, 2);
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so the
  // point pipeline fills and the request channel stalls.
  task automatic test_cell_backpressure();
    wait_drained();
    cell_hold_cycles = 300;
    for (int n = 0; n < 8; n++)
      send_line(pick_coord(-31, 0), pick_coord(0, 31), pick_coord(0, 31), pick_coord(-31, 0));
  endtask

  // Pause the sender until every cell is back, then carry on.
  task automatic test_drain_pause();
    send_line(-3, 2, 4, -1);
    send_line(20, 5, 20, 5);
    wait_drained();
    send_line(-31, 31, 31, -31);
    send_line(0, -31, 0, 31);
  endtask

  // Random requests: mostly short lines inside the grid, plus arbitrary cells,
  // raw codes that land outside the hexagon, and degenerate lines.
  task automatic test_random_lines(input int count);
    int kind, sq, sr, eq, er;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        sq = pick_coord(-31, 31);
        sr = pick_coord(-31, 31);
        eq = clamp_code(sq + pick_coord(-4, 4));
        er = clamp_code(sr + pick_coord(-4, 4));
      end else if (kind <= 6) begin
        sq = pick_coord(-31, 31);
        sr = pick_coord(-31, 31);
        eq = pick_coord(-31, 31);
        er = pick_coord(-31, 31);
      end else if (kind <= 8) begin
        sq = pick_coord(-32, 31);
        sr = pick_coord(-32, 31);
        eq = pick_coord(-32, 31);
        er = pick_coord(-32, 31);
      end else begin
        sq = pick_coord(-32, 31);
        sr = pick_coord(-32, 31);
        eq = sq;
        er = sr;
      end
      send_line(sq, sr, eq, er);
    end
  endtask

  // Closing stretch with no idling on either channel.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_lines(60);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    lines_drawn      = 0;
    cells_checked    = 0;
    mismatches       = 0;
    cell_hold_cycles = 0;
    idle_on          = 1'b1;
    rst              <= 1'b1;
    line_req.valid   <= 1'b0;
    line_req.start_q <= '0;
    line_req.start_r <= '0;
    line_req.end_q   <= '0;
    line_req.end_r   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_grid_extremes();
    test_edge_ties();
    test_cell_backpressure();
    test_drain_pause();
    test_random_lines(360);
    test_steady_stream();

    // Let the last line drain, then give the pipeline tail a few more cycles.
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Drew %0d lines (grid extremes, edge ties, saturation, back-pressure, random).",
             lines_drawn);
    $display("Compared %0d cells, %0d field mismatches.", cells_checked, mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("Timed out with %0d cells outstanding.", cells_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
